### design/mis_pkg.sv
// Shared types and constants for the maximal intersection sweep block.
// No dependencies; used by mis_ctrl, mis_datapath and the top level.
package mis_pkg;

  localparam int unsigned ROWS       = 64;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned HGT_W      = 6;
  localparam int unsigned X_W        = 6;
  localparam int unsigned SWEEP_W    = 7;
  localparam int unsigned MAX_RECTS  = 32;
  localparam int unsigned OUT_CAP    = 32;
  localparam int unsigned RESULT_CAP = (MAX_RECTS < OUT_CAP) ? MAX_RECTS : OUT_CAP;
  localparam int unsigned CNT_W      = $clog2(RESULT_CAP + 1);

  localparam logic [HGT_W-1:0] HGT_MAX = '1;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             rd;
    logic             step;
    logic             fin;
    logic             is_left;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stall;
    logic busy;
  } status_t;

  typedef struct packed {
    logic [X_W-1:0]   x_low;
    logic [X_W-1:0]   x_high;
    logic [ROW_W-1:0] y_low;
    logic [ROW_W-1:0] y_high;
  } result_t;

endpackage

### design/mis_ctrl.sv
// Sequencer for the sweep: walks the row span of one event, read then update.
// Depends on mis_pkg; drives the command struct of mis_datapath.
module mis_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       is_left_edge_i,
  input  logic [mis_pkg::ROW_W-1:0]  row_low_i,
  input  logic [mis_pkg::ROW_W-1:0]  row_high_i,
  input  mis_pkg::status_t           status_i,
  output mis_pkg::cmd_t              cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [mis_pkg::ROW_W-1:0] row_q, row_d;
  logic [mis_pkg::ROW_W-1:0] lo_q, lo_d;
  logic [mis_pkg::ROW_W-1:0] hi_q, hi_d;
  logic                      left_q, left_d;
  logic                      accept;
  logic                      last_row;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_row   = (row_q == hi_q - mis_pkg::ROW_W'(1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    left_d  = left_q;
    cmd_o   = '0;
    cmd_o.is_left = left_q;
    cmd_o.row     = row_q;
    cmd_o.first   = (row_q == lo_q);
    cmd_o.last    = last_row;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          lo_d   = row_low_i;
          hi_d   = row_high_i;
          left_d = is_left_edge_i;
          row_d  = row_low_i;
          state_d = (row_high_i > row_low_i) ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        cmd_o.step = 1'b1;
        if (!status_i.stall) begin
          if (last_row) begin
            state_d = S_FIN;
          end else begin
            row_d   = row_q + mis_pkg::ROW_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (!status_i.busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    left_q <= left_d;
  end

endmodule

### design/mis_datapath.sv
// Row stores, scan registers, pending result and output register of the sweep.
// Depends on mis_pkg; commanded by mis_ctrl.
module mis_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mis_pkg::cmd_t              cmd_i,
  output mis_pkg::status_t           status_o,
  input  logic                       start_sweep_i,
  input  logic [mis_pkg::X_W-1:0]    left_x_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mis_pkg::result_t           out_res_o,
  output logic                       out_last_o
);

  logic [mis_pkg::HGT_W-1:0] hgt_mem [mis_pkg::ROWS];
  logic [mis_pkg::X_W-1:0]   lx_mem  [mis_pkg::ROWS];

  logic [mis_pkg::ROWS-1:0]  hw_q;
  logic [mis_pkg::ROWS-1:0]  lw_q;
  logic [mis_pkg::ROWS-1:0]  ev_q;
  logic [mis_pkg::SWEEP_W-1:0] sweep_q;
  logic [mis_pkg::X_W-1:0]   left_x_q;
  logic [mis_pkg::ROW_W-1:0] addr_q;
  logic [mis_pkg::HGT_W-1:0] hgt_rd_q;
  logic [mis_pkg::X_W-1:0]   lx_rd_q;
  logic [mis_pkg::HGT_W-1:0] prev_h_q;
  logic [mis_pkg::X_W-1:0]   prev_lx_q;
  logic                      has_b_q;
  logic [mis_pkg::ROW_W-1:0] b_q;
  logic                      av_q;
  logic [mis_pkg::CNT_W-1:0] n_q;
  logic                      pend_v_q;
  mis_pkg::result_t          pend_q;
  logic                      out_v_q;
  logic                      out_last_q;
  mis_pkg::result_t          out_q;

  logic [mis_pkg::HGT_W-1:0] h_cur;
  logic [mis_pkg::X_W-1:0]   lx_cur;
  logic                      rise, fall, dec;
  logic                      has_b_n, av_n;
  logic [mis_pkg::ROW_W-1:0] b_n;
  logic                      emit_cmp, emit_fin, emit, keep;
  mis_pkg::result_t          rec;
  logic                      out_free;
  logic                      right_step, left_step, step_go, fin_go, out_load;

  assign h_cur  = hw_q[addr_q] ? hgt_rd_q : '0;
  assign lx_cur = lw_q[addr_q] ? lx_rd_q : '0;
  assign rise   = !cmd_i.first && (h_cur > prev_h_q);
  assign fall   = !cmd_i.first && (h_cur < prev_h_q);
  assign dec    = fall && has_b_q;

  always_comb begin
    if (cmd_i.first || rise) begin
      has_b_n = 1'b1;
      b_n     = addr_q;
      av_n    = ev_q[addr_q];
    end else begin
      has_b_n = dec ? 1'b0 : has_b_q;
      b_n     = b_q;
      av_n    = av_q && ev_q[addr_q];
    end
  end

  assign emit_cmp = dec && av_q;
  assign emit_fin = cmd_i.last && has_b_n && av_n;
  assign emit     = emit_cmp || emit_fin;
  assign keep     = (n_q < mis_pkg::CNT_W'(mis_pkg::RESULT_CAP));

  always_comb begin
    rec.x_high = sweep_q[mis_pkg::X_W-1:0];
    if (emit_cmp) begin
      rec.x_low  = prev_lx_q;
      rec.y_low  = b_q;
      rec.y_high = addr_q;
    end else begin
      rec.x_low  = lx_cur;
      rec.y_low  = b_n;
      rec.y_high = addr_q + mis_pkg::ROW_W'(1);
    end
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign right_step = cmd_i.step && !cmd_i.is_left;
  assign left_step  = cmd_i.step && cmd_i.is_left;
  assign status_o.stall = right_step && emit && keep && pend_v_q && !out_free;
  assign status_o.busy  = pend_v_q && !out_free;
  assign step_go    = right_step && !status_o.stall;
  assign fin_go     = cmd_i.fin && !status_o.busy;
  assign out_load   = pend_v_q && ((step_go && emit && keep) || fin_go);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      hgt_rd_q <= hgt_mem[cmd_i.row];
      lx_rd_q  <= lx_mem[cmd_i.row];
      addr_q   <= cmd_i.row;
    end
    if (left_step) begin
      hgt_mem[addr_q] <= (h_cur == mis_pkg::HGT_MAX) ? h_cur : h_cur + mis_pkg::HGT_W'(1);
      lx_mem[addr_q]  <= left_x_q;
    end else if (step_go && (h_cur != '0)) begin
      hgt_mem[addr_q] <= h_cur - mis_pkg::HGT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_x_q <= left_x_i;
    end
    if (step_go) begin
      prev_h_q  <= h_cur;
      prev_lx_q <= lx_cur;
      has_b_q   <= has_b_n;
      b_q       <= b_n;
      av_q      <= av_n;
    end
    if (step_go && emit && keep) begin
      pend_q <= rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q       <= '0;
      lw_q       <= '0;
      ev_q       <= '0;
      sweep_q    <= '0;
      n_q        <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_q      <= '0;
    end else begin
      if (out_v_q && out_ready_i && !out_load) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.load) begin
        n_q <= '0;
        if (start_sweep_i) begin
          hw_q    <= '0;
          lw_q    <= '0;
          ev_q    <= '0;
          sweep_q <= '0;
        end
      end
      if (left_step) begin
        hw_q[addr_q] <= 1'b1;
        lw_q[addr_q] <= 1'b1;
        ev_q[addr_q] <= 1'b1;
      end
      if (step_go && emit) begin
        ev_q[rec.y_low] <= 1'b0;
        if (keep) begin
          n_q      <= n_q + mis_pkg::CNT_W'(1);
          pend_v_q <= 1'b1;
          if (pend_v_q) begin
            out_q      <= pend_q;
            out_last_q <= 1'b0;
            out_v_q    <= 1'b1;
          end
        end
      end
      if (fin_go) begin
        sweep_q <= sweep_q + mis_pkg::SWEEP_W'(1);
        if (pend_v_q) begin
          out_q      <= pend_q;
          out_last_q <= 1'b1;
          out_v_q    <= 1'b1;
          pend_v_q   <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

### design/maximal_intersection_sweep.sv
// Top level of the maximal intersection sweep: controller plus datapath.
// Depends on mis_pkg, mis_ctrl and mis_datapath.
//
// Takes one sorted x-endpoint event per input beat and returns one beat per
// maximal intersection found on a right edge, the last flagged by
// last_of_run_o. A new event is not accepted until the current one is done,
// and an event can be held while the output side stalls. The row stores are
// single-port with registered reads, so each row of the span is read and
// then updated in turn. Up to 32 results are emitted per event. The row
// stores carry per-row written bits, so reset and start_sweep take effect
// at once with no clearing pass.
module maximal_intersection_sweep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      start_sweep_i,
  input  logic                      is_left_edge_i,
  input  logic [mis_pkg::ROW_W-1:0] row_low_i,
  input  logic [mis_pkg::ROW_W-1:0] row_high_i,
  input  logic [mis_pkg::X_W-1:0]   left_x_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mis_pkg::X_W-1:0]   area_x_low_o,
  output logic [mis_pkg::X_W-1:0]   area_x_high_o,
  output logic [mis_pkg::ROW_W-1:0] area_y_low_o,
  output logic [mis_pkg::ROW_W-1:0] area_y_high_o,
  output logic                      last_of_run_o
);

  mis_pkg::cmd_t    cmd;
  mis_pkg::status_t status;
  mis_pkg::result_t res;

  mis_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_left_edge_i (is_left_edge_i),
    .row_low_i      (row_low_i),
    .row_high_i     (row_high_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  mis_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_sweep_i (start_sweep_i),
    .left_x_i      (left_x_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_res_o     (res),
    .out_last_o    (last_of_run_o)
  );

  assign area_x_low_o  = res.x_low;
  assign area_x_high_o = res.x_high;
  assign area_y_low_o  = res.y_low;
  assign area_y_high_o = res.y_high;

endmodule
